// ===== design/assert_macros.svh =====
// assertion macros shared by the cassette wave generator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define TIWC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define TIWC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/tiwc_pkg.sv =====
// types and constants of the cassette wave generator
package tiwc_pkg;

  localparam int unsigned HEADER_BYTES = 9;

  localparam int unsigned CNT_W   = 17;
  localparam int unsigned PAUSE_W = 12;
  localparam int unsigned LEAD_W  = 10;
  localparam int unsigned GAP_W   = 8;
  localparam int unsigned STOP_W  = 3;
  localparam int unsigned SHIFT_W = 10;
  localparam int unsigned BITS_W  = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [7:0] SYNC_BYTE  = 8'h16;
  localparam logic [7:0] BLOCK_BYTE = 8'h24;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] LVL_SILENT = 2'd0;
  localparam logic [1:0] LVL_HIGH   = 2'd1;
  localparam logic [1:0] LVL_LOW    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEADER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP   = 2'd3;

  localparam logic [PAUSE_W-1:0] PAUSE_RST  = 12'd1200;
  localparam logic [LEAD_W-1:0]  LEADER_RST = 10'd512;
  localparam logic [GAP_W-1:0]   GAP_RST    = 8'd100;
  localparam logic [STOP_W-1:0]  STOP_RST   = 3'd4;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_GOT_SYNC,
    PH_HEADER,
    PH_NAME,
    PH_DATA
  } phase_e;

  typedef struct packed {
    logic       opcode;
    logic [7:0] tape_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] sample_level;
    logic       sample_valid;
    logic       byte_accepted;
    logic       generator_idle;
  } out_item_t;

endpackage

// ===== design/tape_image_to_cassette_wave_unit.sv =====
// top level of the tape image to cassette wave generator
//
//   channel  | handshake                      | payload
//   ---------+--------------------------------+-------------------------------
//   input    | in_valid_i / in_stall_o        | in_data_i: opcode, tape_byte
//   output   | out_valid_o / out_stall_i      | out_data_o: level, flags, idle
//   config   | cfg_we_i, cfg_index_i          | cfg_data_i (12 bits)
//
// one transfer in per cycle unless stalled, its result is held in a two-entry buffer
// parser and sample generator state update in the cycle of the input transfer
// in_stall_o rises only when both buffer entries hold results not yet taken
// reset restores the register defaults and leaves the parser searching for sync

module tape_image_to_cassette_wave_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  tiwc_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output tiwc_pkg::out_item_t             out_data_o,
  input  logic                            cfg_we_i,
  input  logic [tiwc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tiwc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic                in_fire;
  logic                buf_full;
  tiwc_pkg::out_item_t result;

  assign in_stall_o = buf_full;
  assign in_fire    = in_valid_i && !buf_full;

  tiwc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (in_fire),
    .item_i      (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .result_o    (result)
  );

  tiwc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (in_fire),
    .wr_data_i   (result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== design/tiwc_core.sv =====
// tape parser, frame builder and sample generator state
`include "assert_macros.svh"

module tiwc_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                fire_i,
  input  tiwc_pkg::in_item_t                  item_i,
  input  logic                                cfg_we_i,
  input  logic [tiwc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tiwc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output tiwc_pkg::out_item_t                 result_o
);

  // configuration
  logic [tiwc_pkg::PAUSE_W-1:0] cfg_pause_q;
  logic [tiwc_pkg::LEAD_W-1:0]  cfg_leader_q;
  logic [tiwc_pkg::GAP_W-1:0]   cfg_gap_q;
  logic [tiwc_pkg::STOP_W-1:0]  cfg_stop_q;

  // parser and generator state
  tiwc_pkg::phase_e              phase_q, phase_d;
  logic [tiwc_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [tiwc_pkg::CNT_W-1:0]    exp_len_q, exp_len_d;
  logic [7:0]                    hdr_q [4];
  logic                          hdr_we;
  logic [tiwc_pkg::PAUSE_W-1:0]  pause_q, pause_d;
  logic [tiwc_pkg::LEAD_W-1:0]   leader_q, leader_d;
  logic [tiwc_pkg::GAP_W-1:0]    gap_q, gap_d;
  logic [7:0]                    qbyte_q, qbyte_d;
  logic                          qvalid_q, qvalid_d;
  logic [tiwc_pkg::SHIFT_W-1:0]  shift_q, shift_d;
  logic [tiwc_pkg::BITS_W-1:0]   bits_q, bits_d;
  logic [1:0]                    step_q, step_d;

  logic                          idle_now;
  logic [tiwc_pkg::CNT_W-1:0]    cnt_inc;
  logic [15:0]                   end_addr, start_addr;
  logic [tiwc_pkg::CNT_W-1:0]    range_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_pause_q  <= tiwc_pkg::PAUSE_RST;
      cfg_leader_q <= tiwc_pkg::LEADER_RST;
      cfg_gap_q    <= tiwc_pkg::GAP_RST;
      cfg_stop_q   <= tiwc_pkg::STOP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tiwc_pkg::CFG_PAUSE:  cfg_pause_q  <= cfg_data_i[tiwc_pkg::PAUSE_W-1:0];
        tiwc_pkg::CFG_LEADER: cfg_leader_q <= cfg_data_i[tiwc_pkg::LEAD_W-1:0];
        tiwc_pkg::CFG_GAP:    cfg_gap_q    <= cfg_data_i[tiwc_pkg::GAP_W-1:0];
        tiwc_pkg::CFG_STOP:   cfg_stop_q   <= cfg_data_i[tiwc_pkg::STOP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= tiwc_pkg::PH_SEARCH;
      cnt_q     <= '0;
      exp_len_q <= '0;
      pause_q   <= '0;
      leader_q  <= '0;
      gap_q     <= '0;
      qvalid_q  <= 1'b0;
      shift_q   <= '0;
      bits_q    <= '0;
      step_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      exp_len_q <= exp_len_d;
      pause_q   <= pause_d;
      leader_q  <= leader_d;
      gap_q     <= gap_d;
      qvalid_q  <= qvalid_d;
      shift_q   <= shift_d;
      bits_q    <= bits_d;
      step_q    <= step_d;
    end
  end

  // header bytes four to seven hold the end and start addresses
  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_q[cnt_q[1:0]] <= item_i.tape_byte;
    end
    qbyte_q <= qbyte_d;
  end

  assign idle_now   = (bits_q == '0) && (pause_q == '0) && (leader_q == '0) &&
                      !qvalid_q && (gap_q == '0);
  assign cnt_inc    = cnt_q + tiwc_pkg::CNT_W'(1);
  assign end_addr   = {hdr_q[0], hdr_q[1]};
  assign start_addr = {hdr_q[2], hdr_q[3]};
  assign range_len  = (end_addr >= start_addr) ?
                      ({1'b0, end_addr} - {1'b0, start_addr} + tiwc_pkg::CNT_W'(1)) : '0;

  always_comb begin
    logic       load;
    logic [7:0] load_byte;
    logic [7:0] b;
    load      = 1'b0;
    load_byte = tiwc_pkg::SYNC_BYTE;
    b         = item_i.tape_byte;

    phase_d   = phase_q;
    cnt_d     = cnt_q;
    exp_len_d = exp_len_q;
    pause_d   = pause_q;
    leader_d  = leader_q;
    gap_d     = gap_q;
    qbyte_d   = qbyte_q;
    qvalid_d  = qvalid_q;
    shift_d   = shift_q;
    bits_d    = bits_q;
    step_d    = step_q;
    hdr_we    = 1'b0;
    result_o  = '0;
    result_o.sample_level = tiwc_pkg::LVL_SILENT;

    if (fire_i && item_i.opcode == tiwc_pkg::OP_PUSH) begin
      if (idle_now) begin
        result_o.byte_accepted = 1'b1;
        unique case (phase_q)
          tiwc_pkg::PH_SEARCH: begin
            if (b == tiwc_pkg::SYNC_BYTE) phase_d = tiwc_pkg::PH_GOT_SYNC;
          end
          tiwc_pkg::PH_GOT_SYNC: begin
            // any non-sync byte starts pause and leader, a block marker also gets framed
            if (b != tiwc_pkg::SYNC_BYTE) begin
              pause_d  = cfg_pause_q;
              leader_d = cfg_leader_q;
              if (b == tiwc_pkg::BLOCK_BYTE) begin
                qbyte_d  = b;
                qvalid_d = 1'b1;
                phase_d  = tiwc_pkg::PH_HEADER;
                cnt_d    = '0;
              end
            end
          end
          tiwc_pkg::PH_HEADER: begin
            hdr_we   = (cnt_q[tiwc_pkg::CNT_W-1:2] == (tiwc_pkg::CNT_W-2)'(1));
            qbyte_d  = b;
            qvalid_d = 1'b1;
            cnt_d    = cnt_inc;
            if (cnt_inc == tiwc_pkg::CNT_W'(tiwc_pkg::HEADER_BYTES)) begin
              phase_d = tiwc_pkg::PH_NAME;
            end
          end
          tiwc_pkg::PH_NAME: begin
            qbyte_d  = b;
            qvalid_d = 1'b1;
            if (b == 8'h00) begin
              gap_d     = cfg_gap_q;
              phase_d   = tiwc_pkg::PH_DATA;
              cnt_d     = '0;
              exp_len_d = range_len;
            end
          end
          tiwc_pkg::PH_DATA: begin
            qbyte_d  = b;
            qvalid_d = 1'b1;
            // empty range never ends the data phase
            if (exp_len_q != '0) begin
              cnt_d = cnt_inc;
              if (cnt_inc == exp_len_q) phase_d = tiwc_pkg::PH_SEARCH;
            end
          end
          default: phase_d = tiwc_pkg::PH_SEARCH;
        endcase
      end
    end else if (fire_i) begin
      if (bits_q == '0) begin
        if (pause_q != '0) begin
          pause_d                = pause_q - tiwc_pkg::PAUSE_W'(1);
          result_o.sample_valid  = 1'b1;
        end else if (leader_q != '0) begin
          leader_d  = leader_q - tiwc_pkg::LEAD_W'(1);
          load      = 1'b1;
          load_byte = tiwc_pkg::SYNC_BYTE;
        end else if (qvalid_q) begin
          qvalid_d  = 1'b0;
          load      = 1'b1;
          load_byte = qbyte_q;
        end else if (gap_q != '0) begin
          gap_d                 = gap_q - tiwc_pkg::GAP_W'(1);
          shift_d               = tiwc_pkg::SHIFT_W'(1);
          bits_d                = tiwc_pkg::BITS_W'(1);
          step_d                = 2'd1;
          result_o.sample_level = tiwc_pkg::LVL_HIGH;
          result_o.sample_valid = 1'b1;
        end
      end else if (step_q == 2'd0) begin
        step_d                = 2'd1;
        result_o.sample_level = tiwc_pkg::LVL_HIGH;
        result_o.sample_valid = 1'b1;
      end else begin
        result_o.sample_level = tiwc_pkg::LVL_LOW;
        result_o.sample_valid = 1'b1;
        // a zero bit holds one more low sample
        if (step_q == 2'd1 && !shift_q[0]) begin
          step_d = 2'd2;
        end else begin
          step_d  = 2'd0;
          shift_d = {1'b1, shift_q[tiwc_pkg::SHIFT_W-1:1]};
          bits_d  = bits_q - tiwc_pkg::BITS_W'(1);
        end
      end

      // start, data lsb first, parity; stop bits shift in as ones from the top
      if (load) begin
        shift_d               = {~(^load_byte), load_byte, 1'b0};
        bits_d                = tiwc_pkg::BITS_W'(10) + tiwc_pkg::BITS_W'(cfg_stop_q);
        step_d                = 2'd1;
        result_o.sample_level = tiwc_pkg::LVL_HIGH;
        result_o.sample_valid = 1'b1;
      end
    end

    result_o.generator_idle = (bits_d == '0) && (pause_d == '0) && (leader_d == '0) &&
                              !qvalid_d && (gap_d == '0);
  end

  `TIWC_ASSERT(a_step_code, step_q != 2'd3, "bit sample step out of range")
  `TIWC_ASSERT(a_step_in_frame, (step_q == 2'd0) || (bits_q != '0), "sample step outside a frame")
  `TIWC_ASSERT(a_accept_idle, !(result_o.byte_accepted && !idle_now), "byte taken while busy")

endmodule

// ===== design/tiwc_out_buf.sv =====
// two-entry result buffer between the generator and the output channel
`include "assert_macros.svh"

module tiwc_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  tiwc_pkg::out_item_t wr_data_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tiwc_pkg::out_item_t out_data_o
);

  tiwc_pkg::out_item_t entry_q [2];
  logic                wr_ptr_q, rd_ptr_q;
  logic [1:0]          count_q, count_d;
  logic                rd_en;

  assign rd_en       = (count_q != 2'd0) && !out_stall_i;
  assign full_o      = (count_q == 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = entry_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (wr_en_i && !rd_en) count_d = count_q + 2'd1;
    if (!wr_en_i && rd_en) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (wr_en_i) wr_ptr_q <= ~wr_ptr_q;
      if (rd_en)   rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q[wr_ptr_q] <= wr_data_i;
    end
  end

  `TIWC_ASSERT(a_no_overflow, !(wr_en_i && full_o), "write into full result buffer")
  `TIWC_ASSERT_NEXT(a_write_shows, wr_en_i, out_valid_o, "written result not presented")

endmodule

// ===== test/tb_tape_image_to_cassette_wave_unit.sv =====
// self-checking testbench for the tape image to cassette wave generator
module tb_tape_image_to_cassette_wave_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tiwc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned PHASE_ITEMS    = 150;

  typedef struct {
    in_item_t  req;
    out_item_t want;
  } tape_step_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_item_t             out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  tape_step_t  pending_q[$];
  out_item_t   expected_samples_q[$];
  tape_step_t  on_wire;
  int unsigned stim_count;
  int unsigned fails;
  int unsigned send_idle_left;
  int unsigned recv_idle_left;
  int unsigned hold_left;
  int unsigned hold_ask;
  int unsigned hold_seen;
  int unsigned quiet_cycles;
  bit          send_jitter;
  bit          recv_jitter;

  // generator mirror: configuration
  logic [PAUSE_W-1:0] cfg_pause;
  logic [LEAD_W-1:0]  cfg_leader;
  logic [GAP_W-1:0]   cfg_gap;
  logic [STOP_W-1:0]  cfg_stop;

  // generator mirror: parser and sample state
  phase_e      prs_phase;
  logic [16:0] prs_count;
  logic [16:0] data_len;
  logic [7:0]  hdr_bytes [4];
  logic [11:0] pause_cnt;
  logic [9:0]  leader_cnt;
  logic [7:0]  gap_cnt;
  logic [7:0]  next_byte;
  logic        next_byte_ok;
  logic [16:0] bit_shift;
  logic [4:0]  bits_to_go;
  logic [1:0]  half_step;

  tape_image_to_cassette_wave_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void mirror_reset();
    cfg_pause    = PAUSE_RST;
    cfg_leader   = LEADER_RST;
    cfg_gap      = GAP_RST;
    cfg_stop     = STOP_RST;
    prs_phase    = PH_SEARCH;
    prs_count    = '0;
    data_len     = '0;
    foreach (hdr_bytes[i]) hdr_bytes[i] = 8'h00;
    pause_cnt    = '0;
    leader_cnt   = '0;
    gap_cnt      = '0;
    next_byte    = '0;
    next_byte_ok = 1'b0;
    bit_shift    = '0;
    bits_to_go   = '0;
    half_step    = '0;
  endfunction

  function automatic logic wave_idle();
    return bits_to_go == 0 && pause_cnt == 0 && leader_cnt == 0 && !next_byte_ok &&
           gap_cnt == 0;
  endfunction

  // start bit, data lsb first, odd parity, then the stop ones
  function automatic void start_frame(logic [7:0] b);
    bit_shift      = '0;
    bit_shift[8:1] = b;
    bit_shift[9]   = ~^b;
    for (int i = 0; i < cfg_stop; i++) bit_shift[10 + i] = 1'b1;
    bits_to_go = 5'd10 + 5'(cfg_stop);
    half_step  = 2'd0;
  endfunction

  function automatic void take_byte(logic [7:0] b);
    logic [15:0] end_addr;
    logic [15:0] start_addr;
    case (prs_phase)
      PH_SEARCH: begin
        if (b == SYNC_BYTE) prs_phase = PH_GOT_SYNC;
      end
      PH_GOT_SYNC: begin
        if (b != SYNC_BYTE) begin
          pause_cnt  = cfg_pause;
          leader_cnt = cfg_leader;
          if (b == BLOCK_BYTE) begin
            next_byte    = b;
            next_byte_ok = 1'b1;
            prs_phase    = PH_HEADER;
            prs_count    = '0;
          end
        end
      end
      PH_HEADER: begin
        if (prs_count >= 4 && prs_count <= 7) hdr_bytes[prs_count[1:0]] = b;
        next_byte    = b;
        next_byte_ok = 1'b1;
        prs_count    = prs_count + 17'd1;
        if (prs_count == 17'(HEADER_BYTES)) prs_phase = PH_NAME;
      end
      PH_NAME: begin
        next_byte    = b;
        next_byte_ok = 1'b1;
        if (b == 8'h00) begin
          end_addr   = {hdr_bytes[0], hdr_bytes[1]};
          start_addr = {hdr_bytes[2], hdr_bytes[3]};
          gap_cnt    = cfg_gap;
          prs_phase  = PH_DATA;
          prs_count  = '0;
          data_len   = (end_addr >= start_addr) ? 17'(end_addr - start_addr) + 17'd1 : '0;
        end
      end
      PH_DATA: begin
        next_byte    = b;
        next_byte_ok = 1'b1;
        // a backward range never leaves the data phase
        if (data_len != 0) begin
          prs_count = prs_count + 17'd1;
          if (prs_count == data_len) prs_phase = PH_SEARCH;
        end
      end
      default: prs_phase = PH_SEARCH;
    endcase
  endfunction

  function automatic logic wave_tick(output logic [1:0] lvl);
    lvl = LVL_SILENT;
    if (bits_to_go == 0) begin
      if (pause_cnt != 0) begin
        pause_cnt = pause_cnt - 12'd1;
        return 1'b1;
      end
      if (leader_cnt != 0) begin
        leader_cnt = leader_cnt - 10'd1;
        start_frame(SYNC_BYTE);
      end else if (next_byte_ok) begin
        next_byte_ok = 1'b0;
        start_frame(next_byte);
      end else if (gap_cnt != 0) begin
        gap_cnt    = gap_cnt - 8'd1;
        bit_shift  = 17'd1;
        bits_to_go = 5'd1;
        half_step  = 2'd0;
      end else begin
        return 1'b0;
      end
    end
    if (half_step == 2'd0) begin
      lvl       = LVL_HIGH;
      half_step = 2'd1;
      return 1'b1;
    end
    lvl = LVL_LOW;
    // a zero bit holds low for one more sample
    if (half_step == 2'd1 && !bit_shift[0]) begin
      half_step = 2'd2;
    end else begin
      half_step  = 2'd0;
      bit_shift  = bit_shift >> 1;
      bits_to_go = bits_to_go - 5'd1;
    end
    return 1'b1;
  endfunction

  function automatic out_item_t predict_sample(in_item_t req);
    out_item_t  res;
    logic [1:0] lvl;
    res = '0;
    if (req.opcode == OP_PUSH) begin
      if (wave_idle()) begin
        take_byte(req.tape_byte);
        res.byte_accepted = 1'b1;
      end
    end else if (wave_tick(lvl)) begin
      res.sample_level = lvl;
      res.sample_valid = 1'b1;
    end
    res.generator_idle = wave_idle();
    return res;
  endfunction

  function automatic void add_item(logic op, logic [7:0] b);
    tape_step_t s;
    s.req.opcode    = op;
    s.req.tape_byte = b;
    s.want          = predict_sample(s.req);
    if (op == OP_TICK || s.want.byte_accepted) stim_count++;
    pending_q.push_back(s);
  endfunction

  function automatic logic [7:0] edgy_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // tick until the generator is idle, with stray pushes that it must ignore, then push the byte
  function automatic void push_byte(logic [7:0] b);
    while (!wave_idle()) begin
      if ($urandom_range(0, 15) == 0) add_item(OP_PUSH, 8'($urandom));
      add_item(OP_TICK, 8'($urandom));
    end
    if ($urandom_range(0, 9) == 0) add_item(OP_TICK, 8'($urandom));
    add_item(OP_PUSH, b);
  endfunction

  function automatic void finish_samples();
    while (!wave_idle()) add_item(OP_TICK, 8'($urandom));
  endfunction

  function automatic void send_block(int unsigned len, bit backward);
    logic [15:0] first;
    logic [15:0] last;
    logic [7:0]  b;
    if (backward) begin
      first = 16'($urandom_range(1, 16'hFFFF));
      last  = 16'($urandom_range(0, first - 1));
    end else begin
      first = 16'($urandom_range(0, 16'hFFFF - (len - 1)));
      last  = first + 16'(len) - 16'd1;
    end
    repeat ($urandom_range(1, 3)) push_byte(SYNC_BYTE);
    push_byte(BLOCK_BYTE);
    for (int i = 0; i < HEADER_BYTES; i++) begin
      case (i)
        4: b = last[15:8];
        5: b = last[7:0];
        6: b = first[15:8];
        7: b = first[7:0];
        default: b = edgy_byte();
      endcase
      push_byte(b);
    end
    repeat ($urandom_range(0, 3)) begin
      b = edgy_byte();
      push_byte((b == 8'h00) ? 8'hFF : b);
    end
    push_byte(8'h00);
    repeat (len) push_byte(edgy_byte());
  endfunction

  // random bytes outside a block; never opens a header by accident
  function automatic void stray_bytes();
    logic [7:0] b;
    repeat ($urandom_range(1, 4)) begin
      b = ($urandom_range(0, 2) == 0) ? SYNC_BYTE : edgy_byte();
      if (prs_phase == PH_GOT_SYNC && b == BLOCK_BYTE) b = 8'h25;
      push_byte(b);
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || expected_samples_q.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(int unsigned p, int unsigned l, int unsigned g, int unsigned s);
    wait_drained();
    write_reg(CFG_PAUSE, CFG_DATA_W'(p));
    write_reg(CFG_LEADER, CFG_DATA_W'(l));
    write_reg(CFG_GAP, CFG_DATA_W'(g));
    write_reg(CFG_STOP, CFG_DATA_W'(s));
    cfg_pause  = PAUSE_W'(p);
    cfg_leader = LEAD_W'(l);
    cfg_gap    = GAP_W'(g);
    cfg_stop   = STOP_W'(s);
    @(negedge clk_i);
  endtask

  // input side: offer queued items, idle in bursts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) expected_samples_q.push_back(on_wire.want);
      if (!in_valid_i || !in_stall_o) begin
        if (send_idle_left != 0) begin
          send_idle_left--;
          in_valid_i <= 1'b0;
        end else if (send_jitter && $urandom_range(0, 11) == 0) begin
          send_idle_left = $urandom_range(0, 18);
          in_valid_i <= 1'b0;
        end else if (pending_q.size() != 0) begin
          on_wire = pending_q.pop_front();
          in_data_i  <= on_wire.req;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output side: compare each transfer, stall in bursts or one long hold
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_samples_q.size() == 0) begin
          $error("unexpected result %p", out_data_o);
          fails++;
        end else begin
          want = expected_samples_q.pop_front();
          if (out_data_o.sample_level !== want.sample_level) begin
            $error("sample_level: expected %0d, got %0d", want.sample_level,
                   out_data_o.sample_level);
            fails++;
          end
          if (out_data_o.sample_valid !== want.sample_valid) begin
            $error("sample_valid: expected %0d, got %0d", want.sample_valid,
                   out_data_o.sample_valid);
            fails++;
          end
          if (out_data_o.byte_accepted !== want.byte_accepted) begin
            $error("byte_accepted: expected %0d, got %0d", want.byte_accepted,
                   out_data_o.byte_accepted);
            fails++;
          end
          if (out_data_o.generator_idle !== want.generator_idle) begin
            $error("generator_idle: expected %0d, got %0d", want.generator_idle,
                   out_data_o.generator_idle);
            fails++;
          end
        end
      end
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (recv_idle_left != 0) begin
        recv_idle_left--;
        out_stall_i <= 1'b1;
      end else if (recv_jitter && $urandom_range(0, 11) == 0) begin
        recv_idle_left = $urandom_range(0, 18);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("tape_image_to_cassette_wave_unit test failed");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned goal;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_PAUSE;
    cfg_data_i  = '0;
    send_jitter = 1'b1;
    recv_jitter = 1'b1;
    mirror_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset state: tick while idle, bytes before sync, then sync
    add_item(OP_TICK, 8'h5A);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(BLOCK_BYTE);
    push_byte(SYNC_BYTE);
    finish_samples();

    // zero pause, leader and gap: a stray byte after sync schedules nothing
    set_regs(0, 0, 0, 1);
    push_byte(SYNC_BYTE);
    push_byte(8'h33);
    finish_samples();

    // no stop bits; a stray byte after sync still plays pause and leader, then a one-byte block
    set_regs(3, 1, 2, 0);
    push_byte(SYNC_BYTE);
    push_byte(8'h55);
    send_block(1, 1'b0);
    finish_samples();

    for (int ph = 0; ph < 2; ph++) begin
      set_regs($urandom_range(0, 40), $urandom_range(0, 2), $urandom_range(0, 12),
               (ph == 1) ? 7 : $urandom_range(0, 6));
      send_jitter = ($urandom_range(0, 3) != 0);
      recv_jitter = ($urandom_range(0, 3) != 0);
      // block the output long enough for the input side to back up
      if (ph == 0) hold_ask++;
      goal = stim_count + PHASE_ITEMS;
      while (stim_count < goal) begin
        if ($urandom_range(0, 9) < 7) send_block($urandom_range(1, 3), 1'b0);
        else stray_bytes();
      end
      finish_samples();
    end

    // backward data range last: the parser stays in the data phase for good
    set_regs($urandom_range(0, 20), $urandom_range(0, 2), $urandom_range(0, 8),
             $urandom_range(1, 3));
    send_jitter = 1'b0;
    recv_jitter = 1'b0;
    send_block($urandom_range(1, 3), 1'b1);
    repeat (2) push_byte(edgy_byte());
    finish_samples();

    wait_drained();
    repeat (8) @(negedge clk_i);
    if (fails == 0 && expected_samples_q.size() == 0) begin
      $display("tape_image_to_cassette_wave_unit test passed");
    end else begin
      $display("tape_image_to_cassette_wave_unit test failed");
    end
    $finish;
  end

endmodule
